### rtl/eepw_pkg.sv
package eepw_pkg;

    // address, length and tick counter width
    localparam int ADDR_W = 16;
    // chunk length field width
    localparam int LEN_W = 8;
    localparam int CMD_W = 3;
    localparam int PHASE_W = 3;

    // page size, power of two
    localparam int PAGE_BYTES = 128;
    localparam int PAGE_W = $clog2(PAGE_BYTES);

    localparam logic [ADDR_W-1:0] WRITE_TIME_RST = ADDR_W'(5);
    localparam logic [ADDR_W-1:0] TICK_MAX = '1;

    // stream widths, packed fields rounded up to whole bytes
    localparam int S_FIELDS_W = 2 * ADDR_W + 1;
    localparam int S_DATA_W = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 + 2 * ADDR_W + LEN_W + PHASE_W + 1;
    localparam int M_DATA_W = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_START     = 3'd0,
        CMD_POLL      = 3'd1,
        CMD_XFER_DONE = 3'd2,
        CMD_BUS_ERR   = 3'd3,
        CMD_TICK      = 3'd4,
        CMD_CLR_ERR   = 3'd5
    } t_cmd;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE      = 3'd0,
        PH_WRITE     = 3'd1,
        PH_WAIT_XFER = 3'd2,
        PH_WAIT_TIME = 3'd3,
        PH_DONE      = 3'd4,
        PH_ERROR     = 3'd5
    } t_phase;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] start_addr;
        logic [ADDR_W-1:0] length;
        logic              launch_ok;
    } t_item;

    typedef struct packed {
        logic               accepted;
        logic               busy_res;
        logic               issue_chunk;
        logic [ADDR_W-1:0]  chunk_addr;
        logic [LEN_W-1:0]   chunk_len;
        logic [ADDR_W-1:0]  data_offset;
        logic [PHASE_W-1:0] phase;
        logic               error_seen;
    } t_result;

    function automatic logic is_busy(input t_phase ph);
        return (ph == PH_WRITE) || (ph == PH_WAIT_XFER) || (ph == PH_WAIT_TIME);
    endfunction

endpackage

### rtl/eepw_in_reg.sv
module eepw_in_reg
    import eepw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    // a slot frees up when the held beat moves on
    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### rtl/eepw_core.sv
module eepw_core
    import eepw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  t_item             i_item,
    input  logic              i_cfg_wr_en,
    input  logic [ADDR_W-1:0] i_cfg_wr_data,
    output t_result           o_result
);

    localparam logic [PAGE_W:0] PAGE_SPAN = (PAGE_W + 1)'(PAGE_BYTES);

    t_phase            r_phase, n_phase;
    logic [ADDR_W-1:0] r_next_addr, n_next_addr;
    logic [ADDR_W-1:0] r_bytes_left, n_bytes_left;
    logic [ADDR_W-1:0] r_src_off, n_src_off;
    logic [ADDR_W-1:0] r_elapsed, n_elapsed;
    logic              r_err, n_err;
    logic [ADDR_W-1:0] r_write_time;

    logic [PAGE_W:0]   w_room;
    logic [ADDR_W-1:0] w_room_ext;
    logic [ADDR_W-1:0] w_size;
    logic              w_issue;
    t_result           w_res;

    // bytes to the next page boundary, clipped to what is left
    assign w_room     = PAGE_SPAN - {1'b0, r_next_addr[PAGE_W-1:0]};
    assign w_room_ext = ADDR_W'(w_room);
    assign w_size     = (w_room_ext < r_bytes_left) ? w_room_ext : r_bytes_left;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_time <= WRITE_TIME_RST;
        end else if (i_cfg_wr_en) begin
            r_write_time <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_next_addr  <= '0;
            r_bytes_left <= '0;
            r_src_off    <= '0;
            r_elapsed    <= '0;
            r_err        <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_next_addr  <= n_next_addr;
            r_bytes_left <= n_bytes_left;
            r_src_off    <= n_src_off;
            r_elapsed    <= n_elapsed;
            r_err        <= n_err;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_next_addr  = r_next_addr;
        n_bytes_left = r_bytes_left;
        n_src_off    = r_src_off;
        n_elapsed    = r_elapsed;
        n_err        = r_err;
        w_issue      = 1'b0;
        w_res        = '0;
        if (i_step) begin
            unique case (t_cmd'(i_item.command))
                CMD_START: begin
                    if (!is_busy(r_phase) && (i_item.length != '0)) begin
                        n_next_addr  = i_item.start_addr;
                        n_bytes_left = i_item.length;
                        n_src_off    = '0;
                        n_err        = 1'b0;
                        n_phase      = PH_WRITE;
                        w_res.accepted = 1'b1;
                    end
                end
                CMD_POLL: begin
                    if (r_phase == PH_WRITE) begin
                        if (r_bytes_left == '0) begin
                            n_phase = PH_DONE;
                        end else if (!i_item.launch_ok) begin
                            n_err   = 1'b1;
                            n_phase = PH_ERROR;
                        end else begin
                            w_issue            = 1'b1;
                            w_res.issue_chunk  = 1'b1;
                            w_res.chunk_addr   = r_next_addr;
                            w_res.chunk_len    = w_size[LEN_W-1:0];
                            w_res.data_offset  = r_src_off;
                            n_src_off          = r_src_off + w_size;
                            n_bytes_left       = r_bytes_left - w_size;
                            n_next_addr        = r_next_addr + w_size;
                            n_phase            = PH_WAIT_XFER;
                        end
                    end else if (r_phase == PH_WAIT_TIME) begin
                        if (r_elapsed >= r_write_time) begin
                            n_phase = PH_WRITE;
                        end
                    end
                end
                CMD_XFER_DONE: begin
                    if (r_phase == PH_WAIT_XFER) begin
                        n_elapsed = '0;
                        n_phase   = PH_WAIT_TIME;
                    end
                end
                CMD_BUS_ERR: begin
                    n_err   = 1'b1;
                    n_phase = PH_ERROR;
                end
                CMD_TICK: begin
                    if ((r_phase == PH_WAIT_TIME) && (r_elapsed != TICK_MAX)) begin
                        n_elapsed = r_elapsed + 1'b1;
                    end
                end
                CMD_CLR_ERR: begin
                    w_res.error_seen = r_err;
                    n_err            = 1'b0;
                end
                default: begin
                end
            endcase
        end
        w_res.phase    = n_phase;
        w_res.busy_res = is_busy(n_phase);
    end

    assign o_result = w_res;

`ifndef SYNTHESIS
    // a launched chunk always leaves the sequencer waiting for the transfer
    a_issue_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> (r_phase == PH_WAIT_XFER))
        else $error("chunk launch did not enter wait transfer");

    // chunk size is nonzero and never crosses a page boundary
    a_chunk_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |-> ((w_size != '0) && (w_size <= w_room_ext)))
        else $error("chunk size out of range");

    // remaining bytes shrink by exactly the launched chunk
    a_bytes_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> (r_bytes_left == $past(r_bytes_left - w_size)))
        else $error("remaining byte count mismatch");

    // an accepted start clears the sticky error and enters chunk issue
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && w_res.accepted) |=> (!r_err && (r_phase == PH_WRITE)))
        else $error("accepted start left stale state");
`endif

endmodule

### rtl/eepw_out_reg.sv
module eepw_out_reg
    import eepw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_can_take,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_can_take = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_take) begin
            r_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_take && i_push) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

### rtl/eeprom_page_write_sequencer.sv
// a result beat passes the input register, then the result register; a held beat
// waits in the input register while the result register cannot take it
// throughput one beat per cycle while the result stream keeps taking beats
// the whole step is one pass of next-state logic with one page-boundary clip
// reset (i_rst_n low, synchronous): phase idle, counters and sticky error
// cleared, write time back to 5 ticks, both stream registers emptied
module eeprom_page_write_sequencer
    import eepw_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: ticks to wait after each chunk transfer
    input  logic                i_cfg_wr_en,
    input  logic [ADDR_W-1:0]   i_cfg_wr_data,
    // command stream
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    // tdata: start_addr[15:0], length[31:16], launch_ok[32], zero fill
    input  logic [S_DATA_W-1:0] i_s_axis_tdata,
    // tuser: command[2:0]
    input  logic [CMD_W-1:0]    i_s_axis_tuser,
    // result stream
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // tdata: accepted[0], busy_res[1], issue_chunk[2], chunk_addr[18:3],
    // chunk_len[26:19], data_offset[42:27], phase[45:43], error_seen[46], zero fill
    output logic [M_DATA_W-1:0] o_m_axis_tdata
);

    t_item   w_in_item;
    t_item   w_held_item;
    logic    w_held_valid;
    logic    w_can_take;
    logic    w_step;
    t_result w_core_res;
    t_result w_out_res;

    // unpack the beat into the item fields
    always_comb begin
        w_in_item.command    = i_s_axis_tuser;
        w_in_item.start_addr = i_s_axis_tdata[ADDR_W-1:0];
        w_in_item.length     = i_s_axis_tdata[2*ADDR_W-1:ADDR_W];
        w_in_item.launch_ok  = i_s_axis_tdata[2*ADDR_W];
    end

    // held beat steps the state whenever the result register can take it
    assign w_step = w_held_valid && w_can_take;

    eepw_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .i_item    (w_in_item),
        .i_advance (w_can_take),
        .o_ready   (o_s_axis_tready),
        .o_valid   (w_held_valid),
        .o_item    (w_held_item)
    );

    eepw_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_step),
        .i_item        (w_held_item),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (w_core_res)
    );

    eepw_out_reg u_out_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_held_valid),
        .i_result   (w_core_res),
        .i_ready    (i_m_axis_tready),
        .o_can_take (w_can_take),
        .o_valid    (o_m_axis_tvalid),
        .o_result   (w_out_res)
    );

    // pack result fields, first field in the low bits
    always_comb begin
        o_m_axis_tdata                                   = '0;
        o_m_axis_tdata[0]                                = w_out_res.accepted;
        o_m_axis_tdata[1]                                = w_out_res.busy_res;
        o_m_axis_tdata[2]                                = w_out_res.issue_chunk;
        o_m_axis_tdata[3 +: ADDR_W]                      = w_out_res.chunk_addr;
        o_m_axis_tdata[3 + ADDR_W +: LEN_W]              = w_out_res.chunk_len;
        o_m_axis_tdata[3 + ADDR_W + LEN_W +: ADDR_W]     = w_out_res.data_offset;
        o_m_axis_tdata[3 + 2*ADDR_W + LEN_W +: PHASE_W]  = w_out_res.phase;
        o_m_axis_tdata[3 + 2*ADDR_W + LEN_W + PHASE_W]   = w_out_res.error_seen;
    end

endmodule

### bench/eeprom_page_write_sequencer_test.sv
module eeprom_page_write_sequencer_test;
    import eepw_pkg::*;

    // command codes outside the defined set, the block must ignore them
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;

    // random stimulus size and the quiet tail at the end of the run
    localparam int ITEM_TARGET = 950;
    localparam int QUIET_TAIL = 150;
    // cycles without any beat on either side before the run is abandoned
    localparam int STALL_LIMIT = 300;
    // result beat follows its command beat after two register stages
    localparam int PIPE_DEPTH = 2;
    // steps per job before a bus error cuts it short
    localparam int JOB_BUDGET = 60;

    // running model of the sequencer and the queue of results it owes
    class page_write_tracker;
        t_phase            phase;
        logic [ADDR_W-1:0] next_addr;
        logic [ADDR_W-1:0] bytes_left;
        logic [ADDR_W-1:0] src_offset;
        logic [ADDR_W-1:0] elapsed;
        logic [ADDR_W-1:0] write_time;
        logic              err_sticky;
        t_result           due_results[$];
        int                mismatches;

        function new();
            phase = PH_IDLE;
            next_addr = '0;
            bytes_left = '0;
            src_offset = '0;
            elapsed = '0;
            write_time = WRITE_TIME_RST;
            err_sticky = 1'b0;
            mismatches = 0;
        endfunction

        function bit busy();
            return phase == PH_WRITE || phase == PH_WAIT_XFER || phase == PH_WAIT_TIME;
        endfunction

        function void set_write_time(logic [ADDR_W-1:0] ticks);
            write_time = ticks;
        endfunction

        // advance the model by one accepted command beat and queue its result
        function void note_command(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                   logic [ADDR_W-1:0] len, logic lok);
            t_result r;
            int      room;
            int      size;
            r = '0;
            case (cmd)
                CMD_START: begin
                    if (!busy() && len != '0) begin
                        next_addr = addr;
                        bytes_left = len;
                        src_offset = '0;
                        err_sticky = 1'b0;
                        phase = PH_WRITE;
                        r.accepted = 1'b1;
                    end
                end
                CMD_POLL: begin
                    if (phase == PH_WRITE) begin
                        if (bytes_left == '0) begin
                            phase = PH_DONE;
                        end else if (!lok) begin
                            err_sticky = 1'b1;
                            phase = PH_ERROR;
                        end else begin
                            // clip at the page boundary and at the bytes still owed
                            room = PAGE_BYTES - (int'(next_addr) % PAGE_BYTES);
                            size = (room < int'(bytes_left)) ? room : int'(bytes_left);
                            r.issue_chunk = 1'b1;
                            r.chunk_addr = next_addr;
                            r.chunk_len = LEN_W'(size);
                            r.data_offset = src_offset;
                            src_offset = src_offset + ADDR_W'(size);
                            bytes_left = bytes_left - ADDR_W'(size);
                            next_addr = next_addr + ADDR_W'(size);
                            phase = PH_WAIT_XFER;
                        end
                    end else if (phase == PH_WAIT_TIME) begin
                        if (elapsed >= write_time)
                            phase = PH_WRITE;
                    end
                end
                CMD_XFER_DONE: begin
                    if (phase == PH_WAIT_XFER) begin
                        elapsed = '0;
                        phase = PH_WAIT_TIME;
                    end
                end
                CMD_BUS_ERR: begin
                    err_sticky = 1'b1;
                    phase = PH_ERROR;
                end
                CMD_TICK: begin
                    if (phase == PH_WAIT_TIME && elapsed != TICK_MAX)
                        elapsed = elapsed + 1'b1;
                end
                CMD_CLR_ERR: begin
                    r.error_seen = err_sticky;
                    err_sticky = 1'b0;
                end
                default: ;
            endcase
            r.busy_res = busy();
            r.phase = phase;
            due_results.push_back(r);
        endfunction

        function string show(t_result r);
            return $sformatf("acc=%0d busy=%0d issue=%0d addr=%h len=%0d off=%h ph=%0d err=%0d",
                             r.accepted, r.busy_res, r.issue_chunk, r.chunk_addr,
                             r.chunk_len, r.data_offset, r.phase, r.error_seen);
        endfunction

        function void check_result(logic [M_DATA_W-1:0] beat);
            t_result got;
            t_result want;
            got.accepted = beat[0];
            got.busy_res = beat[1];
            got.issue_chunk = beat[2];
            got.chunk_addr = beat[18:3];
            got.chunk_len = beat[26:19];
            got.data_offset = beat[42:27];
            got.phase = beat[45:43];
            got.error_seen = beat[46];
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing outstanding: %s", show(got));
                return;
            end
            want = due_results.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch\n  expected %s\n  actual   %s",
                             show(want), show(got));
            end
        endfunction
    endclass

    // all block inputs start at known values
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [ADDR_W-1:0]   i_cfg_wr_data = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    // tdata: start_addr[15:0], length[31:16], launch_ok[32], zero fill
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;
    // tuser: command[2:0]
    logic [CMD_W-1:0]    i_s_axis_tuser = '0;
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // tdata: accepted[0], busy_res[1], issue_chunk[2], chunk_addr[18:3],
    // chunk_len[26:19], data_offset[42:27], phase[45:43], error_seen[46], zero fill
    logic [M_DATA_W-1:0] o_m_axis_tdata;

    page_write_tracker tracker = new();
    int  beats_sent = 0;
    int  hold_cycles = 0;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;

    eeprom_page_write_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check each beat taken, stall in short random bursts while rx_idle is set
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            tracker.check_result(o_m_axis_tdata);
        if (hold_cycles != 0) begin
            hold_cycles <= hold_cycles - 1;
            i_m_axis_tready <= (hold_cycles == 1);
        end else if (rx_idle && $urandom_range(0, 4) == 0) begin
            hold_cycles <= $urandom_range(1, 3);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // watchdog: ends the run once neither side has moved a beat for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("eeprom_page_write_sequencer regression: fail");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] rnd16();
        return ADDR_W'($urandom);
    endfunction

    // one command beat; valid stays high into the next beat unless a gap is drawn
    task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [ADDR_W-1:0] len, input logic lok);
        int gap;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser <= cmd;
        i_s_axis_tdata <= {(S_DATA_W - S_FIELDS_W)'(0), lok, len, addr};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        tracker.note_command(cmd, addr, len, lok);
        beats_sent++;
    endtask

    // any command code with random fields
    task automatic send_noise();
        send_beat(CMD_W'($urandom_range(0, 7)), rnd16(), rnd16(), 1'($urandom));
    endtask

    // stop sending and wait for every owed result beat
    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (tracker.due_results.size() != 0) @(posedge i_clk);
    endtask

    // write time is only changed with the block drained
    task automatic load_write_time(input logic [ADDR_W-1:0] ticks);
        settle();
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= ticks;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tracker.set_write_time(ticks);
    endtask

    // one page-write job: start, then poll / done / ticks until it finishes or fails
    task automatic run_job();
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] len;
        int                pick;
        int                steps;
        pick = $urandom_range(0, 99);
        if (pick < 40)
            addr = rnd16();
        else if (pick < 75)
            // just short of a page boundary
            addr = {rnd16()} | ADDR_W'(PAGE_BYTES - 1) - ADDR_W'($urandom_range(0, 7));
        else if (pick < 90)
            // near the top, so the address wraps
            addr = 16'hFFFF - ADDR_W'($urandom_range(0, 300));
        else
            addr = ADDR_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 99);
        if (pick < 65)
            len = ADDR_W'($urandom_range(1, 300));
        else if (pick < 85)
            len = ADDR_W'($urandom_range(1, 4));
        else if (pick < 93)
            len = rnd16();
        else if (pick < 97)
            len = 16'hFFFF;
        else
            len = '0;
        send_beat(CMD_START, addr, len, 1'($urandom));
        steps = 0;
        while (tracker.busy()) begin
            steps++;
            if (steps > JOB_BUDGET)
                send_beat(CMD_BUS_ERR, rnd16(), rnd16(), 1'($urandom));
            else if ($urandom_range(0, 19) == 0)
                send_noise();
            else
                case (tracker.phase)
                    PH_WRITE:
                        send_beat(CMD_POLL, rnd16(), rnd16(), $urandom_range(0, 24) != 0);
                    PH_WAIT_XFER:
                        send_beat(CMD_XFER_DONE, rnd16(), rnd16(), 1'($urandom));
                    default: begin
                        // occasionally poll early while the write time is still running
                        if (tracker.elapsed >= tracker.write_time || $urandom_range(0, 9) == 0)
                            send_beat(CMD_POLL, rnd16(), rnd16(), 1'($urandom));
                        else
                            send_beat(CMD_TICK, rnd16(), rnd16(), 1'($urandom));
                    end
                endcase
        end
        if ($urandom_range(0, 2) == 0)
            send_beat(CMD_CLR_ERR, rnd16(), rnd16(), 1'($urandom));
    endtask

    logic [ADDR_W-1:0] write_times[6] = '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd7, 16'd2};

    initial begin : stimulus
        int target;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part, write time still at its reset value of 5
        send_beat(CMD_CLR_ERR, 16'h0000, 16'h0000, 1'b0);
        send_beat(CMD_START, 16'hFFFF, 16'h0000, 1'b1);   // zero length refused
        send_beat(CMD_POLL, 16'h0000, 16'h0000, 1'b1);    // idle, nothing happens
        send_beat(CMD_XFER_DONE, 16'h0000, 16'h0000, 1'b0);
        send_beat(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        send_beat(CMD_RSVD_LO, 16'hFFFF, 16'hFFFF, 1'b1);
        send_beat(CMD_RSVD_HI, 16'hFFFF, 16'hFFFF, 1'b1);
        // first chunk runs to the top (16 bytes), then the address wraps with 4 bytes left
        send_beat(CMD_START, 16'hFFF0, 16'd20, 1'b0);
        send_beat(CMD_START, 16'h0000, 16'hFFFF, 1'b1);   // refused while busy
        send_beat(CMD_POLL, 16'h0000, 16'h0000, 1'b1);
        send_beat(CMD_POLL, 16'h0000, 16'h0000, 1'b1);    // waiting for transfer
        send_beat(CMD_TICK, 16'h0000, 16'h0000, 1'b1);    // not counted here
        send_beat(CMD_XFER_DONE, 16'h0000, 16'h0000, 1'b1);
        send_beat(CMD_POLL, 16'h0000, 16'h0000, 1'b1);    // write time not yet over
        repeat (5) send_beat(CMD_TICK, 16'h0000, 16'h0000, 1'b0);
        send_beat(CMD_POLL, 16'h0000, 16'h0000, 1'b1);    // back to chunk issue
        send_beat(CMD_POLL, 16'h0000, 16'h0000, 1'b0);    // launch refused
        send_beat(CMD_CLR_ERR, 16'h0000, 16'h0000, 1'b0); // sticky error read back
        send_beat(CMD_CLR_ERR, 16'h0000, 16'h0000, 1'b0);
        send_beat(CMD_START, 16'h0080, 16'd128, 1'b1);    // one whole page
        send_beat(CMD_POLL, 16'h0000, 16'h0000, 1'b1);
        send_beat(CMD_BUS_ERR, 16'h0000, 16'h0000, 1'b0);

        // random part, one write time setting per stretch
        foreach (write_times[i]) begin
            load_write_time(write_times[i]);
            tx_idle = (i != 1);
            rx_idle = (i != 3);
            target = beats_sent + ITEM_TARGET / 6;
            while (beats_sent < target) begin
                // last part of the run goes without gaps on either side
                if (i == 5 && target - beats_sent <= QUIET_TAIL) begin
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
                if ($urandom_range(0, 9) == 0)
                    send_noise();
                else
                    run_job();
            end
        end

        settle();
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
        if (tracker.mismatches == 0)
            $display("eeprom_page_write_sequencer regression: pass");
        else
            $display("eeprom_page_write_sequencer regression: fail");
        $finish;
    end

endmodule

### sim.f
rtl/eepw_pkg.sv
rtl/eepw_in_reg.sv
rtl/eepw_core.sv
rtl/eepw_out_reg.sv
rtl/eeprom_page_write_sequencer.sv
bench/eeprom_page_write_sequencer_test.sv
